@@ design/hec_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hec_pkg
// Types, codes and helper functions shared by the hamming codec files.
// ---------------------------------------------------------------------------
package hec_pkg;

	localparam int WordBits  = 63;
	localparam int MsgBits   = 57;
	localparam int SynBits   = 6;
	localparam int LenBits   = 6;

	// command codes
	localparam logic CmdEncode = 1'b0;
	localparam logic CmdCheck  = 1'b1;

	// status codes
	localparam logic [1:0] StatusOk        = 2'd0;
	localparam logic [1:0] StatusCorrected = 2'd1;
	localparam logic [1:0] StatusBeyond    = 2'd2;

	// register map, index taken from paddr[2]
	localparam logic RegMessageLength = 1'b0;

	localparam logic [LenBits-1:0] MsgLenReset = 6'd4;

	typedef struct packed {
		logic                cmd;
		logic [WordBits-1:0] bits_in;
	} in_item_t;

	typedef struct packed {
		logic [WordBits-1:0] codeword_out;
		logic [SynBits-1:0]  syndrome;
		logic [1:0]          status;
	} out_item_t;

	// smallest r with 2^r >= m + r + 1, m in 1..57
	function automatic logic [2:0] parity_count(input logic [LenBits-1:0] m);
		logic [2:0] r;
		logic       found;
		r     = 3'd6;
		found = 1'b0;
		for (int k = 1; k <= 6; k++) begin
			if (!found && ((7'd1 << k) >= (7'(m) + 7'(k) + 7'd1))) begin
				r     = 3'(k);
				found = 1'b1;
			end
		end
		return r;
	endfunction

	// positions (1-based) whose bit k is set
	function automatic logic [WordBits-1:0] pos_mask(input int k);
		logic [WordBits-1:0] mask;
		mask = '0;
		for (int p = 1; p <= WordBits; p++) begin
			mask[p-1] = ((p >> k) & 1) != 0;
		end
		return mask;
	endfunction

	// spread message bits over the non power-of-two positions in order
	function automatic logic [WordBits-1:0] place_message(input logic [MsgBits-1:0] msg);
		logic [WordBits-1:0] cw;
		int                  idx;
		cw  = '0;
		idx = 0;
		for (int p = 1; p <= WordBits; p++) begin
			if ((p & (p - 1)) != 0) begin
				cw[p-1] = msg[idx];
				idx++;
			end
		end
		return cw;
	endfunction

endpackage

@@ design/hec_stream_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hec_stream_if
// Valid/ready channel carrying one payload struct per transfer.
// ---------------------------------------------------------------------------
interface hec_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ design/hamming_encode_correct.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hamming_encode_correct
// Single-error-correcting Hamming encoder and checker, programmable length.
// ---------------------------------------------------------------------------
// Takes one transfer per clock while dout.ready is high and returns one result
// per transfer, in order. Stage 1 masks or places the input bits, stage 2
// builds the six parity / syndrome xor trees, stage 3 inserts the parity bits
// or flips the failing bit and holds the result for the output channel. Each
// stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so an output stall fills empty stages before din.ready drops.
// message_length (byte address 0) sets the message bits m in use; values are
// clamped to 1..MAX_MESSAGE_BITS. Codeword length is n = m + r with r the
// smallest parity count for which 2^r >= m + r + 1. Bits of codeword_out at
// and above n are always zero. Write the register only while the pipe is
// empty. There is no memory and no clearing pass after reset.
// ---------------------------------------------------------------------------
module hamming_encode_correct #(
	parameter int MAX_MESSAGE_BITS = 57
) (
	input  logic        clk,
	input  logic        arst_n,

	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// item channels
	hec_stream_if.sink   din,
	hec_stream_if.source dout
);

	localparam logic [hec_pkg::LenBits-1:0] MaxLen = hec_pkg::LenBits'(MAX_MESSAGE_BITS);

	// ------------------------------------------------------------------
	// configuration register
	// ------------------------------------------------------------------
	logic [hec_pkg::LenBits-1:0] msg_len_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= hec_pkg::MsgLenReset;
		end else if (psel && penable && pwrite && (paddr[2] == hec_pkg::RegMessageLength)) begin
			msg_len_q <= pwdata[hec_pkg::LenBits-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == hec_pkg::RegMessageLength) begin
			prdata = {{(32-hec_pkg::LenBits){1'b0}}, msg_len_q};
		end
	end

	// effective length, code length and masks derived from the register
	logic [hec_pkg::LenBits-1:0]  len_eff;
	logic [hec_pkg::LenBits-1:0]  code_len;
	logic [hec_pkg::WordBits-1:0] code_mask;
	logic [hec_pkg::MsgBits-1:0]  msg_mask;

	always_comb begin
		if (msg_len_q == '0) begin
			len_eff = hec_pkg::LenBits'(1);
		end else if (msg_len_q > MaxLen) begin
			len_eff = MaxLen;
		end else begin
			len_eff = msg_len_q;
		end
		code_len  = len_eff + hec_pkg::LenBits'(hec_pkg::parity_count(len_eff));
		code_mask = hec_pkg::WordBits'((64'd1 << code_len) - 64'd1);
		msg_mask  = hec_pkg::MsgBits'((64'd1 << len_eff) - 64'd1);
	end

	// ------------------------------------------------------------------
	// pipeline control: a stage takes new data when empty or draining
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3  = !valid_s3 || dout.ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign din.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= din.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: place message bits (encode) or trim to n bits (check)
	// ------------------------------------------------------------------
	logic                         cmd_s1;
	logic [hec_pkg::WordBits-1:0] word_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && din.valid) begin
			cmd_s1 <= din.payload.cmd;
			if (din.payload.cmd == hec_pkg::CmdEncode) begin
				// data positions of the first m message bits all lie below n
				word_s1 <= hec_pkg::place_message(
					din.payload.bits_in[hec_pkg::MsgBits-1:0] & msg_mask);
			end else begin
				word_s1 <= din.payload.bits_in & code_mask;
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 2: xor trees; with parity positions still zero on encode
	// the same trees give the parity values
	// ------------------------------------------------------------------
	logic                         cmd_s2;
	logic [hec_pkg::WordBits-1:0] word_s2;
	logic [hec_pkg::SynBits-1:0]  syn_s2;
	logic [hec_pkg::SynBits-1:0]  syn_d;

	always_comb begin
		for (int k = 0; k < hec_pkg::SynBits; k++) begin
			syn_d[k] = ^(word_s1 & hec_pkg::pos_mask(k));
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			cmd_s2  <= cmd_s1;
			word_s2 <= word_s1;
			syn_s2  <= syn_d;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: insert parity bits or correct the failing position
	// ------------------------------------------------------------------
	logic                         cmd_s3;
	hec_pkg::out_item_t           res_s3;
	hec_pkg::out_item_t           res_d;
	logic [hec_pkg::WordBits-1:0] par_bits;
	logic [hec_pkg::WordBits-1:0] flip_bit;

	always_comb begin
		par_bits = '0;
		for (int k = 0; k < hec_pkg::SynBits; k++) begin
			par_bits[(1 << k) - 1] = syn_s2[k];
		end
		// one-hot at position syn, zero when syn is zero
		flip_bit = hec_pkg::WordBits'((64'd1 << syn_s2) >> 1);

		res_d = '0;
		if (cmd_s2 == hec_pkg::CmdEncode) begin
			res_d.codeword_out = (word_s2 | par_bits) & code_mask;
			res_d.syndrome     = '0;
			res_d.status       = hec_pkg::StatusOk;
		end else begin
			res_d.syndrome = syn_s2;
			if (syn_s2 == '0) begin
				res_d.codeword_out = word_s2;
				res_d.status       = hec_pkg::StatusOk;
			end else if (syn_s2 <= code_len) begin
				res_d.codeword_out = word_s2 ^ flip_bit;
				res_d.status       = hec_pkg::StatusCorrected;
			end else begin
				// syndrome points past the codeword, pass it on untouched
				res_d.codeword_out = word_s2;
				res_d.status       = hec_pkg::StatusBeyond;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			cmd_s3 <= cmd_s2;
			res_s3 <= res_d;
		end
	end

	assign dout.valid   = valid_s3;
	assign dout.payload = res_s3;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_encode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (cmd_s3 == hec_pkg::CmdEncode)) |->
			((res_s3.syndrome == '0) && (res_s3.status == hec_pkg::StatusOk)))
		else $error("encode result carries a syndrome or error status");

	a_corrected_has_syn: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (res_s3.status == hec_pkg::StatusCorrected)) |->
			((res_s3.syndrome != '0) && (res_s3.syndrome <= code_len)))
		else $error("correction reported without a syndrome inside the code");

	a_beyond_past_len: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (res_s3.status == hec_pkg::StatusBeyond)) |->
			(res_s3.syndrome > code_len))
		else $error("out of range status with an in range syndrome");

	a_upper_bits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> ((res_s3.codeword_out & ~code_mask) == '0))
		else $error("codeword bits set beyond the code length");

endmodule
